// ----- design/newton_cube_root_assert.svh -----
// Assertion macros shared by the cube root design files.
`ifndef NEWTON_CUBE_ROOT_ASSERT_SVH
`define NEWTON_CUBE_ROOT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NCR_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NCR_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

// ----- design/ncr_pkg.sv -----
package ncr_pkg;

    // Default number of fraction bits of operand and root
    localparam int FRAC_BITS_DEF = 16;

    // Field and register widths
    localparam int OPERAND_W = 32;
    localparam int ROOT_W    = 23;
    localparam int TOL_W     = 16;
    localparam int LIMIT_W   = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Datapath widths: divider, estimate (< 2^61) and second quotient (<= 2^62)
    localparam int DIV_W = 64;
    localparam int Y_W   = 62;
    localparam int Q_W   = 63;

    // Second quotient saturates here
    localparam logic [DIV_W-1:0] Q_SAT = DIV_W'(1) << 62;

    // Division by three: one 16-bit digit per cycle, remainder carried in two bits
    localparam int D3_DIGIT_W = 16;
    localparam int D3_CHUNK_W = D3_DIGIT_W + 2;
    localparam int D3_STEPS   = DIV_W / D3_DIGIT_W;
    localparam int D3_CNT_W   = $clog2(D3_STEPS + 1);

    // Newton step divides the weighted sum by three
    localparam logic [D3_CHUNK_W-1:0] NEWTON_DEN = D3_CHUNK_W'(3);

    // Reciprocal of three, ceil(2^19 / 3), exact for every 18-bit chunk below 3 * 2^16
    localparam logic [D3_CHUNK_W-1:0] D3_RECIP = D3_CHUNK_W'(174763);
    localparam int                    D3_SHIFT = 19;

    // Largest root magnitude the root field holds
    localparam logic [ROOT_W-2:0] ROOT_MAG_MAX = '1;

    // Reset values of the configuration registers
    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_Q1,
        ST_Q2,
        ST_SUM,
        ST_Y3,
        ST_FINISH
    } state_t;

endpackage

// ----- design/ncr_div.sv -----
`include "newton_cube_root_assert.svh"

module ncr_div #(
    parameter int WIDTH = ncr_pkg::DIV_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] num,
    input  logic [WIDTH-1:0] den,
    output logic             done,
    output logic [WIDTH-1:0] quo
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   rem_diff;
    logic             fits;

    // Trial subtract of one restoring step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
    end

    // Load on start, then retire one quotient bit per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(WIDTH);
            quo_next = num;
            rem_next = '0;
            den_next = den;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? rem_diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
            quo_next  = {quo_reg[WIDTH-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    // A division is only started on an idle divider
    `NCR_ASSERT_NOW(a_div_start_idle, clk, rst_n, start, cnt_reg == '0)

endmodule

// ----- design/newton_cube_root.sv -----
// Signed fixed-point cube root by Newton iteration. Pulse start while busy is low to
// hand over one operand; busy stays high until the result appears on root and
// converged, marked by done for exactly one cycle, which the receiver must take then.
// Each Newton step runs two serial divisions (a/y, then by y again) in one
// shared restoring divider, then divides the weighted sum by three sixteen bits a
// cycle, with the LOOP, SUM and closing Y3 states for sequencing; the second division
// is skipped when the first quotient saturates. A zero operand skips the iteration.
// Tolerance and iteration limit are to be written by the user through
// wr_en/wr_index/wr_data while the block is idle; the block itself does not enforce this.
`include "newton_cube_root_assert.svh"

module newton_cube_root #(
    parameter int FRAC_BITS = ncr_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [ncr_pkg::OPERAND_W-1:0] operand,
    output logic                             done,
    output logic signed [ncr_pkg::ROOT_W-1:0] root,
    output logic                             converged,
    input  logic                             wr_en,
    input  logic [ncr_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ncr_pkg::CFG_W-1:0]        wr_data
);

    localparam int DW = ncr_pkg::DIV_W;
    localparam int YW = ncr_pkg::Y_W;
    localparam int QW = ncr_pkg::Q_W;
    localparam int OW = ncr_pkg::OPERAND_W;
    localparam int RW = ncr_pkg::ROOT_W;
    localparam int LW = ncr_pkg::LIMIT_W;
    localparam int TW = ncr_pkg::TOL_W;
    localparam int GW = ncr_pkg::D3_DIGIT_W;
    localparam int CW = ncr_pkg::D3_CHUNK_W;
    localparam int PW = 2 * ncr_pkg::D3_CHUNK_W;
    localparam int NW = ncr_pkg::D3_CNT_W;

    // First quotient above this saturates the second one
    localparam logic [DW-1:0] Q1_LIMIT = ncr_pkg::Q_SAT >> FRAC_BITS;

    ncr_pkg::state_t state_reg, state_next;

    logic [TW-1:0] tol_reg, tol_next;
    logic [LW-1:0] lim_reg, lim_next;
    logic [LW-1:0] iter_reg, iter_next;
    logic          done_reg, done_next;

    logic [OW-1:0] a_reg, a_next;
    logic          neg_reg, neg_next;
    logic [YW-1:0] y_reg, y_next;
    logic [QW-1:0] q_reg, q_next;
    logic          conv_reg, conv_next;
    logic [RW-1:0] root_reg, root_next;
    logic          converged_reg, converged_next;

    logic [DW-1:0] d3_reg, d3_next;
    logic [1:0]    d3_rem_reg, d3_rem_next;
    logic [NW-1:0] d3_cnt_reg, d3_cnt_next;

    logic          accept;
    logic [OW-1:0] mag_in;
    logic          div_start;
    logic [DW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [DW-1:0] div_quo;
    logic [YW-1:0] y_new;
    logic [YW-1:0] y_diff;
    logic          small_step;
    logic          q1_sat;
    logic [DW-1:0] q2_clip;
    logic [RW-2:0] root_mag;
    logic [CW-1:0] d3_chunk;
    logic [PW-1:0] d3_prod;
    logic [GW-1:0] d3_digit;
    logic [CW-1:0] d3_back;

    assign accept = start && !busy;
    assign mag_in = operand[OW-1] ? OW'(-operand) : OW'(operand);

    // One digit of the division by three: reciprocal multiply, then remainder
    always_comb
    begin
        d3_chunk = {d3_rem_reg, d3_reg[DW-1 -: GW]};
        d3_prod  = PW'(d3_chunk) * PW'(ncr_pkg::D3_RECIP);
        d3_digit = d3_prod[ncr_pkg::D3_SHIFT +: GW];
        d3_back  = d3_chunk - CW'(d3_digit) * ncr_pkg::NEWTON_DEN;
    end

    // Step result and its distance from the current estimate
    always_comb
    begin
        y_new      = d3_reg[YW-1:0];
        y_diff     = (y_new > y_reg) ? (y_new - y_reg) : (y_reg - y_new);
        small_step = (y_diff < YW'(tol_reg));
        q1_sat     = (div_quo > Q1_LIMIT);
        q2_clip    = (div_quo > ncr_pkg::Q_SAT) ? ncr_pkg::Q_SAT : div_quo;
        root_mag   = (y_reg > YW'(ncr_pkg::ROOT_MAG_MAX)) ? ncr_pkg::ROOT_MAG_MAX
                                                          : y_reg[RW-2:0];
    end

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ncr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (mag_in == '0) ? ncr_pkg::ST_FINISH : ncr_pkg::ST_LOOP;
                end
            end
            ncr_pkg::ST_LOOP:
            begin
                if (iter_reg >= lim_reg || y_reg == '0)
                begin
                    state_next = ncr_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = ncr_pkg::ST_Q1;
                end
            end
            ncr_pkg::ST_Q1:
            begin
                if (div_done)
                begin
                    state_next = q1_sat ? ncr_pkg::ST_SUM : ncr_pkg::ST_Q2;
                end
            end
            ncr_pkg::ST_Q2:
            begin
                if (div_done)
                begin
                    state_next = ncr_pkg::ST_SUM;
                end
            end
            ncr_pkg::ST_SUM:
            begin
                state_next = ncr_pkg::ST_Y3;
            end
            ncr_pkg::ST_Y3:
            begin
                if (d3_cnt_reg == '0)
                begin
                    state_next = small_step ? ncr_pkg::ST_FINISH : ncr_pkg::ST_LOOP;
                end
            end
            ncr_pkg::ST_FINISH:
            begin
                state_next = ncr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ncr_pkg::ST_IDLE;
            end
        endcase
    end

    // Divider commands
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DW'(y_reg);
        case (state_reg)
            ncr_pkg::ST_LOOP:
            begin
                div_start = (iter_reg < lim_reg) && (y_reg != '0);
                div_num   = DW'(a_reg) << FRAC_BITS;
            end
            ncr_pkg::ST_Q1:
            begin
                div_start = div_done && !q1_sat;
                div_num   = div_quo << FRAC_BITS;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath and configuration next values
    always_comb
    begin
        tol_next       = tol_reg;
        lim_next       = lim_reg;
        iter_next      = iter_reg;
        done_next      = 1'b0;
        a_next         = a_reg;
        neg_next       = neg_reg;
        y_next         = y_reg;
        q_next         = q_reg;
        conv_next      = conv_reg;
        root_next      = root_reg;
        converged_next = converged_reg;
        d3_next        = d3_reg;
        d3_rem_next    = d3_rem_reg;
        d3_cnt_next    = d3_cnt_reg;

        if (wr_en)
        begin
            case (wr_index)
                ncr_pkg::REG_TOLERANCE:  tol_next = wr_data[TW-1:0];
                ncr_pkg::REG_ITER_LIMIT: lim_next = wr_data[LW-1:0];
                default:                 tol_next = tol_reg;
            endcase
        end

        case (state_reg)
            ncr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    a_next    = mag_in;
                    neg_next  = operand[OW-1];
                    y_next    = YW'(mag_in);
                    iter_next = '0;
                    conv_next = (mag_in == '0);
                end
            end
            ncr_pkg::ST_Q1:
            begin
                if (div_done && q1_sat)
                begin
                    q_next = ncr_pkg::Q_SAT[QW-1:0];
                end
            end
            ncr_pkg::ST_Q2:
            begin
                if (div_done)
                begin
                    q_next = q2_clip[QW-1:0];
                end
            end
            ncr_pkg::ST_SUM:
            begin
                // Load the weighted sum for the division by three
                d3_next     = DW'({y_reg, 1'b0}) + DW'(q_reg);
                d3_rem_next = '0;
                d3_cnt_next = NW'(ncr_pkg::D3_STEPS);
            end
            ncr_pkg::ST_Y3:
            begin
                if (d3_cnt_reg != '0)
                begin
                    // Shift out one dividend digit, shift in one quotient digit
                    d3_next     = {d3_reg[DW-GW-1:0], d3_digit};
                    d3_rem_next = d3_back[1:0];
                    d3_cnt_next = d3_cnt_reg - NW'(1);
                end
                else
                begin
                    y_next    = y_new;
                    iter_next = iter_reg + LW'(1);
                    conv_next = small_step;
                end
            end
            ncr_pkg::ST_FINISH:
            begin
                root_next      = neg_reg ? -{1'b0, root_mag} : {1'b0, root_mag};
                converged_next = conv_reg;
                done_next      = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ncr_pkg::ST_IDLE;
            tol_reg    <= ncr_pkg::TOL_RESET;
            lim_reg    <= ncr_pkg::LIMIT_RESET;
            iter_reg   <= '0;
            done_reg   <= 1'b0;
            d3_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tol_reg    <= tol_next;
            lim_reg    <= lim_next;
            iter_reg   <= iter_next;
            done_reg   <= done_next;
            d3_cnt_reg <= d3_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        neg_reg       <= neg_next;
        y_reg         <= y_next;
        q_reg         <= q_next;
        conv_reg      <= conv_next;
        root_reg      <= root_next;
        converged_reg <= converged_next;
        d3_reg        <= d3_next;
        d3_rem_reg    <= d3_rem_next;
    end

    ncr_div #(
        .WIDTH (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign busy      = (state_reg != ncr_pkg::ST_IDLE);
    assign done      = done_reg;
    assign root      = root_reg;
    assign converged = converged_reg;

    // Accepted item keeps the block busy
    `NCR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // Result strobe lasts one cycle
    `NCR_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // Result is shown only once the sequencer is back at rest
    `NCR_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    // Divider finishes only while the sequencer waits for it
    `NCR_ASSERT_NOW(a_div_wait, clk, rst_n, div_done, state_reg inside {ncr_pkg::ST_Q1, ncr_pkg::ST_Q2})

endmodule

// ----- bench/newton_cube_root_test.sv -----
module newton_cube_root_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ncr_pkg::OPERAND_W-1:0]     operand;
        logic signed [ncr_pkg::ROOT_W-1:0] root;
        logic                              converged;
    } root_result_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic signed [ncr_pkg::OPERAND_W-1:0] operand;
    logic                                 done;
    logic signed [ncr_pkg::ROOT_W-1:0]    root;
    logic                                 converged;
    logic                                 wr_en;
    logic [ncr_pkg::CFG_IDX_W-1:0]        wr_index;
    logic [ncr_pkg::CFG_W-1:0]            wr_data;

    // Bench copy of the configuration registers
    logic [ncr_pkg::TOL_W-1:0]   cfg_tolerance;
    logic [ncr_pkg::LIMIT_W-1:0] cfg_limit;

    logic [ncr_pkg::OPERAND_W-1:0] pending_operands[$];
    root_result_t                  expected_roots[$];
    root_result_t                  oldest_root;

    int     send_idle_pct;
    int     items_issued;
    int     roots_checked;
    int     roots_converged;
    int     settings_count;
    int     mismatches;
    longint cycle_count;
    longint cycle_budget;

    newton_cube_root dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand   (operand),
        .done      (done),
        .root      (root),
        .converged (converged),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Newton iteration on the magnitude, sign restored at the end
    function automatic root_result_t predict_cube_root(
        logic [ncr_pkg::OPERAND_W-1:0] x,
        logic [ncr_pkg::TOL_W-1:0]     tol,
        logic [ncr_pkg::LIMIT_W-1:0]   lim);
        root_result_t   r;
        logic           neg;
        logic [63:0]    mag;
        logic [63:0]    y;
        logic [63:0]    y_next;
        logic [63:0]    q1;
        logic [63:0]    q;
        logic [63:0]    diff;
        logic [31:0]    mag32;
        int             i;
        r.operand   = x;
        r.converged = 1'b0;
        neg   = x[ncr_pkg::OPERAND_W-1];
        mag32 = neg ? (~x + 32'd1) : x;
        mag   = {32'd0, mag32};
        if (mag == 64'd0)
        begin
            r.root      = '0;
            r.converged = 1'b1;
            return r;
        end
        y = mag;
        for (i = 0; i < int'(lim); i++)
        begin
            if (y == 64'd0)
            begin
                r.converged = 1'b0;
                break;
            end
            q1 = (mag << ncr_pkg::FRAC_BITS_DEF) / y;
            if (q1 > (ncr_pkg::Q_SAT >> ncr_pkg::FRAC_BITS_DEF))
                q = ncr_pkg::Q_SAT;
            else
                q = (q1 << ncr_pkg::FRAC_BITS_DEF) / y;
            if (q > ncr_pkg::Q_SAT)
                q = ncr_pkg::Q_SAT;
            y_next = (64'd2 * y + q) / 64'd3;
            diff   = (y_next > y) ? (y_next - y) : (y - y_next);
            y      = y_next;
            if (diff < {48'd0, tol})
            begin
                r.converged = 1'b1;
                break;
            end
        end
        // Clamp to the widest magnitude the root field holds
        if (y > {42'd0, ncr_pkg::ROOT_MAG_MAX})
            y = {42'd0, ncr_pkg::ROOT_MAG_MAX};
        r.root = neg ? (~y[ncr_pkg::ROOT_W-1:0] + 1'b1) : y[ncr_pkg::ROOT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Queue one operand and widen the run budget by its worst-case cost
    task automatic queue_operand(logic [ncr_pkg::OPERAND_W-1:0] x);
        pending_operands.push_back(x);
        items_issued++;
        cycle_budget += 220 * (longint'(cfg_limit) + 1) + 100;
    endtask

    task automatic wait_all_roots();
        while (roots_checked != items_issued)
            @(posedge clk);
    endtask

    // Write both registers while the block is idle
    task automatic apply_settings(logic [ncr_pkg::TOL_W-1:0] tol,
                                  logic [ncr_pkg::CFG_W-1:0] lim_word);
        wait_all_roots();
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= ncr_pkg::REG_TOLERANCE;
        wr_data  <= tol;
        cfg_tolerance = tol;
        @(posedge clk);
        wr_index <= ncr_pkg::REG_ITER_LIMIT;
        wr_data  <= lim_word;
        cfg_limit = lim_word[ncr_pkg::LIMIT_W-1:0];
        @(posedge clk);
        wr_en <= 1'b0;
        settings_count++;
    endtask

    // Mostly moderate magnitudes, which converge in a handful of steps
    function automatic logic [ncr_pkg::OPERAND_W-1:0] random_operand();
        int unsigned                   kind;
        int unsigned                   k;
        logic [ncr_pkg::OPERAND_W-1:0] m;
        kind = $urandom_range(0, 99);
        if (kind < 15)
            return $urandom;
        if (kind < 55)
            m = $urandom_range(32'h0000_1000, 32'h0040_0000);
        else if (kind < 70)
            m = 32'h0001_0000 + $urandom_range(0, 4095) - 32'd2048;
        else if (kind < 85)
        begin
            k = $urandom_range(0, 31);
            m = (k * k * k) << ncr_pkg::FRAC_BITS_DEF;
        end
        else if (kind < 93)
            m = $urandom_range(1, 255);
        else
            m = $urandom_range(32'h0040_0000, 32'h7FFF_FFFF);
        if ($urandom_range(0, 1) == 1)
            m = ~m + 32'd1;
        return m;
    endfunction

    // Driver: present the next operand, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            operand <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_roots.push_back(predict_cube_root(operand, cfg_tolerance, cfg_limit));
            if (!start || !busy)
            begin
                if (pending_operands.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    start   <= 1'b1;
                    operand <= pending_operands.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done pulse must match the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_roots.size() == 0)
                report_mismatch($sformatf("unexpected root %0d converged %0b", root, converged));
            else
            begin
                oldest_root = expected_roots.pop_front();
                roots_checked++;
                if (oldest_root.converged)
                    roots_converged++;
                if (root !== oldest_root.root)
                    report_mismatch($sformatf("operand %08h: root %0d, want %0d",
                                              oldest_root.operand, root, oldest_root.root));
                if (converged !== oldest_root.converged)
                    report_mismatch($sformatf("operand %08h: converged %0b, want %0b",
                                              oldest_root.operand, converged,
                                              oldest_root.converged));
            end
        end
    end

    // Watchdog against a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 4 * cycle_budget + 20000)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("[newton_cube_root] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [ncr_pkg::TOL_W-1:0] tol;
        logic [ncr_pkg::CFG_W-1:0] lim_word;
        int                        g;
        int                        n;
        int unsigned               pick;
        rst_n    = 1'b0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        cfg_tolerance   = ncr_pkg::TOL_RESET;
        cfg_limit       = ncr_pkg::LIMIT_RESET;
        send_idle_pct   = 35;
        items_issued    = 0;
        roots_checked   = 0;
        roots_converged = 0;
        settings_count  = 0;
        mismatches      = 0;
        cycle_count     = 0;
        cycle_budget    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero, extremes, exact cubes, signs
        queue_operand(32'h0000_0000);
        queue_operand(32'h7FFF_FFFF);
        queue_operand(32'h8000_0000);
        queue_operand(32'h0000_0001);
        queue_operand(32'hFFFF_FFFF);
        queue_operand(32'h0001_0000);
        queue_operand(32'hFFFF_0000);
        queue_operand(32'h0008_0000);
        queue_operand(~(32'd27 << ncr_pkg::FRAC_BITS_DEF) + 32'd1);

        // Zero tolerance never converges: run to the largest limit
        apply_settings(16'd0, {8'd0, 8'd255});
        queue_operand(32'h0001_0000);

        // Widest tolerance
        apply_settings(16'hFFFF, {8'd0, 8'd255});
        queue_operand(32'h7FFF_FFFF);
        queue_operand(32'hFFFF_FFFB);

        // No step at all: start value returned, saturated where it exceeds the root field
        apply_settings(16'd1, {8'd0, 8'd0});
        queue_operand(32'h7FFF_FFFF);
        queue_operand(32'h8000_0000);
        queue_operand(32'h0001_2345);
        queue_operand(32'h0000_0000);

        // One step only
        apply_settings(16'd0, {8'd0, 8'd1});
        queue_operand(32'h0000_0001);
        queue_operand(~(32'd64 << ncr_pkg::FRAC_BITS_DEF) + 32'd1);
        queue_operand(32'h0001_0000);

        // Random groups, each with its own settings
        for (g = 0; g < 10; g++)
        begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: tol = 16'd0;
                1: tol = 16'd1;
                2: tol = ncr_pkg::TOL_W'($urandom_range(2, 255));
                3: tol = ncr_pkg::TOL_W'($urandom_range(0, 65535));
                default: tol = 16'hFFFF;
            endcase
            lim_word = ncr_pkg::CFG_W'($urandom);
            pick = $urandom_range(0, 9);
            if (tol == 16'd0)
                lim_word[ncr_pkg::LIMIT_W-1:0] = ncr_pkg::LIMIT_W'($urandom_range(0, 8));
            else if (pick == 0)
                lim_word[ncr_pkg::LIMIT_W-1:0] = 8'd0;
            else if (pick == 1)
                lim_word[ncr_pkg::LIMIT_W-1:0] = 8'd1;
            else
                lim_word[ncr_pkg::LIMIT_W-1:0] = ncr_pkg::LIMIT_W'($urandom_range(2, 24));
            apply_settings(tol, lim_word);
            if (g == 4)
                send_idle_pct = 56;
            else if (g == 7)
                send_idle_pct = 0;
            for (n = 0; n < 40; n++)
                queue_operand(random_operand());
        end

        // Drain, then allow a quiet tail for stray results
        wait_all_roots();
        repeat (400) @(posedge clk);

        $display("Checked %0d cube roots under %0d register settings plus reset values;",
                 roots_checked, settings_count);
        $display("%0d met the tolerance, %0d stopped at the limit or a zero estimate.",
                 roots_converged, roots_checked - roots_converged);
        if (mismatches == 0 && expected_roots.size() == 0)
            $display("[newton_cube_root] OK");
        else
            $display("[newton_cube_root] ERROR");
        $finish;
    end

endmodule
